// ----- rtl/core/stv_pkg.sv -----
// shared constants, codes and types of the scrolling text window
package stv_pkg;

  // text store and window geometry
  localparam int TEXT_DEPTH   = 64;
  localparam int WINDOW_WIDTH = 10;
  localparam int CNT_W        = $clog2(TEXT_DEPTH);
  localparam int IDX_W        = CNT_W + 1;
  localparam int COL_W        = 4;
  localparam int CHAR_W       = 8;
  localparam int TIME_W       = 32;
  localparam int CFG_W        = 16;
  localparam int OUT_DATA_W   = 16;

  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;
  localparam logic [CFG_W-1:0]  SCROLL_IVL_RST = 16'd300;
  localparam logic [CFG_W-1:0]  END_PAUSE_RST  = 16'd1000;
  localparam logic [CNT_W-1:0]  WIN_LEN  = CNT_W'(WINDOW_WIDTH);
  localparam logic [CNT_W-1:0]  MAX_CNT  = CNT_W'(TEXT_DEPTH - 1);
  localparam logic [COL_W-1:0]  LAST_COL = COL_W'(WINDOW_WIDTH - 1);

  // configuration register indexes
  typedef enum logic {
    REG_SCROLL_INTERVAL = 1'b0,
    REG_END_PAUSE       = 1'b1
  } cfg_reg_e;

  // input item kinds
  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_BYTE = 1'b1
  } cmd_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_PAUSE_CHK,
    ST_ELAPSED,
    ST_INTERVAL,
    ST_STEP,
    ST_ARM,
    ST_LAUNCH,
    ST_WAIT
  } state_e;

  // operands of the shared adder
  typedef struct packed {
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
    logic              sub;
  } alu_op_t;

  // frame request from the sequencer
  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] len;
  } frame_req_t;

  // frame generator status
  typedef struct packed {
    logic busy;
  } frame_sts_t;

endpackage

// ----- rtl/core/stv_ram.sv -----
// generic single-port-write ram with registered read
module stv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write and registered read, data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/stv_alu.sv -----
// shared 32-bit add/subtract unit with carry out
module stv_alu (
  input  stv_pkg::alu_op_t          op_i,
  output logic [stv_pkg::TIME_W-1:0] sum_o,
  output logic                       carry_o
);

  logic [stv_pkg::TIME_W-1:0] b_eff;

  // subtract as a plus inverted b plus one, carry set means no borrow
  assign b_eff = op_i.sub ? ~op_i.b : op_i.b;
  assign {carry_o, sum_o} = {1'b0, op_i.a} + {1'b0, b_eff}
                          + {{stv_pkg::TIME_W{1'b0}}, op_i.sub};

endmodule

// ----- rtl/core/stv_frame.sv -----
// frame generator: reads one window column per cycle into the output register while it is free or being taken
module stv_frame (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  stv_pkg::frame_req_t          req_i,
  output stv_pkg::frame_sts_t          sts_o,
  output logic                         rd_en_o,
  output logic [stv_pkg::CNT_W-1:0]    rd_addr_o,
  input  logic [stv_pkg::CHAR_W-1:0]   rd_data_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [stv_pkg::COL_W-1:0]    pos_o,
  output logic [stv_pkg::CHAR_W-1:0]   char_o,
  output logic                         last_o
);

  logic                         busy_q;
  logic [stv_pkg::COL_W-1:0]    col_q;
  logic [stv_pkg::CNT_W-1:0]    base_q;
  logic [stv_pkg::CNT_W-1:0]    len_q;
  logic                         rng_q, rng_d;
  logic                         valid_q;
  logic [stv_pkg::COL_W-1:0]    pos_q;
  logic [stv_pkg::CHAR_W-1:0]   char_q;
  logic                         last_q;

  logic                         can_load;
  logic                         done_col;
  logic [stv_pkg::COL_W-1:0]    nxt_col;
  logic [stv_pkg::IDX_W-1:0]    rd_idx;
  logic [stv_pkg::CNT_W-1:0]    rd_len;

  // column advance when the output register is free or being taken
  assign can_load = busy_q & (~valid_q | ready_i);
  assign done_col = (col_q == stv_pkg::LAST_COL);
  assign nxt_col  = col_q + 1'b1;

  // read address of the next column, first column on start
  assign rd_idx  = req_i.start ? {1'b0, req_i.pos}
                               : ({1'b0, base_q} + stv_pkg::IDX_W'(nxt_col));
  assign rd_len  = req_i.start ? req_i.len : len_q;
  assign rd_en_o = req_i.start | (can_load & ~done_col);
  assign rd_addr_o = rd_idx[stv_pkg::CNT_W-1:0];
  assign rng_d   = rd_en_o ? (rd_idx < {1'b0, rd_len}) : rng_q;

  // column sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      col_q  <= '0;
      rng_q  <= 1'b0;
    end else begin
      rng_q <= rng_d;
      if (req_i.start) begin
        busy_q <= 1'b1;
        col_q  <= '0;
      end else if (can_load) begin
        if (done_col) begin
          busy_q <= 1'b0;
        end else begin
          col_q <= nxt_col;
        end
      end
    end
  end

  // frame base and text length
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      base_q <= req_i.pos;
      len_q  <= req_i.len;
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // output register payload, space past the end of text
  always_ff @(posedge clk_i) begin
    if (can_load) begin
      pos_q  <= col_q;
      char_q <= rng_q ? rd_data_i : stv_pkg::SPACE_CHAR;
      last_q <= done_col;
    end
  end

  assign sts_o.busy = busy_q;
  assign valid_o    = valid_q;
  assign pos_o      = pos_q;
  assign char_o     = char_q;
  assign last_o     = last_q;

`ifndef SYNTHESIS
  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("frame start while a frame is in progress");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (col_q <= stv_pkg::LAST_COL))
    else $error("column counter past the window");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (can_load && done_col) |=> (!busy_q && valid_q && last_q))
    else $error("last column did not close the frame");
`endif

endmodule

// ----- rtl/core/scrolling_text_window.sv -----
// Scrolling text window: keeps up to 63 text characters in a 64-entry store and
// emits 10-character frames of a scrolling window. A tick ends after the tick
// count when no scroll decision is due (partial load or short text), after the
// pause check when the pause has not run out, after the interval check when the
// interval has not, and otherwise runs the shared 32-bit adder steps (tick count,
// pause check, elapsed time, interval check, pause rearm at the end of the text)
// before the frame starts. A frame puts one column per cycle into the output
// register while the output is not stalled, reading the text store's single read
// port, and holds the block until its last column is loaded; a committing byte rearms the pause first.
module scrolling_text_window (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // input items
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [stv_pkg::CHAR_W-1:0]         s_axis_tdata,   // text_byte[7:0]
  input  logic                               s_axis_tuser,   // cmd[0]
  input  logic                               s_axis_tlast,   // final_byte
  // result items
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [stv_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // position[3:0], frame_char[11:4]
  output logic                               m_axis_tlast,   // frame_last
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic                               cfg_idx_i,
  input  logic [stv_pkg::CFG_W-1:0]          cfg_data_i
);

  stv_pkg::state_e              state_q, state_d;
  logic [stv_pkg::TIME_W-1:0]   time_now_q, time_now_d;
  logic [stv_pkg::TIME_W-1:0]   last_scroll_q, last_scroll_d;
  logic [stv_pkg::TIME_W-1:0]   pause_until_q, pause_until_d;
  logic [stv_pkg::TIME_W-1:0]   diff_q, diff_d;
  logic [stv_pkg::CNT_W-1:0]    text_len_q, text_len_d;
  logic [stv_pkg::CNT_W-1:0]    load_cnt_q, load_cnt_d;
  logic [stv_pkg::CNT_W-1:0]    scroll_pos_q, scroll_pos_d;
  logic                         loading_q, loading_d;
  logic                         zero_seen_q, zero_seen_d;
  logic [stv_pkg::CFG_W-1:0]    scroll_ivl_q;
  logic [stv_pkg::CFG_W-1:0]    end_pause_q;

  logic                         accept;
  logic                         is_byte;
  logic [stv_pkg::CNT_W-1:0]    eff_cnt;
  logic                         zero_now;
  logic                         wr_ok;
  logic [stv_pkg::CNT_W-1:0]    new_cnt;
  logic                         len_gt_win;
  logic [stv_pkg::CNT_W-1:0]    last_pos;
  logic [stv_pkg::CNT_W-1:0]    pos_inc;

  stv_pkg::alu_op_t             alu_op;
  logic [stv_pkg::TIME_W-1:0]   alu_sum;
  logic                         alu_co;

  stv_pkg::frame_req_t          frm_req;
  stv_pkg::frame_sts_t          frm_sts;
  logic                         rd_en;
  logic [stv_pkg::CNT_W-1:0]    rd_addr;
  logic [stv_pkg::CHAR_W-1:0]   rd_data;
  logic [stv_pkg::COL_W-1:0]    frm_pos;
  logic [stv_pkg::CHAR_W-1:0]   frm_char;

  // input handshake
  assign s_axis_tready = (state_q == stv_pkg::ST_IDLE);
  assign accept  = s_axis_tvalid & s_axis_tready;
  assign is_byte = (s_axis_tuser == stv_pkg::CMD_BYTE);

  // text load bookkeeping, a new load starts from an empty count
  assign eff_cnt  = loading_q ? load_cnt_q : '0;
  assign zero_now = (loading_q & zero_seen_q) | (s_axis_tdata == '0);
  assign wr_ok    = accept & is_byte & ~zero_now & (eff_cnt < stv_pkg::MAX_CNT);
  assign new_cnt  = eff_cnt + {{(stv_pkg::CNT_W-1){1'b0}}, wr_ok};

  // scroll limits
  assign len_gt_win = (text_len_q > stv_pkg::WIN_LEN);
  assign last_pos   = text_len_q - stv_pkg::WIN_LEN;
  assign pos_inc    = scroll_pos_q + 1'b1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      stv_pkg::ST_IDLE: begin
        if (accept) begin
          if (!is_byte) begin
            state_d = stv_pkg::ST_TICK;
          end else if (s_axis_tlast) begin
            state_d = stv_pkg::ST_ARM;
          end
        end
      end
      stv_pkg::ST_TICK: begin
        state_d = (loading_q || !len_gt_win) ? stv_pkg::ST_IDLE : stv_pkg::ST_PAUSE_CHK;
      end
      stv_pkg::ST_PAUSE_CHK: begin
        state_d = alu_co ? stv_pkg::ST_ELAPSED : stv_pkg::ST_IDLE;
      end
      stv_pkg::ST_ELAPSED: begin
        state_d = stv_pkg::ST_INTERVAL;
      end
      stv_pkg::ST_INTERVAL: begin
        state_d = alu_co ? stv_pkg::ST_STEP : stv_pkg::ST_IDLE;
      end
      stv_pkg::ST_STEP: begin
        state_d = (pos_inc >= last_pos) ? stv_pkg::ST_ARM : stv_pkg::ST_LAUNCH;
      end
      stv_pkg::ST_ARM: begin
        state_d = stv_pkg::ST_LAUNCH;
      end
      stv_pkg::ST_LAUNCH: begin
        state_d = stv_pkg::ST_WAIT;
      end
      stv_pkg::ST_WAIT: begin
        state_d = frm_sts.busy ? stv_pkg::ST_WAIT : stv_pkg::ST_IDLE;
      end
      default: begin
        state_d = stv_pkg::ST_IDLE;
      end
    endcase
  end

  // adder operands and frame request per state
  always_comb begin
    alu_op.a   = time_now_q;
    alu_op.b   = '0;
    alu_op.sub = 1'b0;
    case (state_q)
      stv_pkg::ST_TICK: begin
        alu_op.b = stv_pkg::TIME_W'(1);
      end
      stv_pkg::ST_PAUSE_CHK: begin
        alu_op.b   = pause_until_q;
        alu_op.sub = 1'b1;
      end
      stv_pkg::ST_ELAPSED: begin
        alu_op.b   = last_scroll_q;
        alu_op.sub = 1'b1;
      end
      stv_pkg::ST_INTERVAL: begin
        alu_op.a   = diff_q;
        alu_op.b   = stv_pkg::TIME_W'(scroll_ivl_q);
        alu_op.sub = 1'b1;
      end
      stv_pkg::ST_ARM: begin
        alu_op.b = stv_pkg::TIME_W'(end_pause_q);
      end
      default: begin
        alu_op.b = '0;
      end
    endcase
    frm_req.start = (state_q == stv_pkg::ST_LAUNCH);
    frm_req.pos   = scroll_pos_q;
    frm_req.len   = text_len_q;
  end

  // state register updates
  always_comb begin
    time_now_d    = time_now_q;
    last_scroll_d = last_scroll_q;
    pause_until_d = pause_until_q;
    diff_d        = diff_q;
    text_len_d    = text_len_q;
    load_cnt_d    = load_cnt_q;
    scroll_pos_d  = scroll_pos_q;
    loading_d     = loading_q;
    zero_seen_d   = zero_seen_q;
    case (state_q)
      stv_pkg::ST_IDLE: begin
        if (accept && is_byte) begin
          loading_d   = ~s_axis_tlast;
          load_cnt_d  = new_cnt;
          zero_seen_d = zero_now;
          if (s_axis_tlast) begin
            text_len_d    = new_cnt;
            scroll_pos_d  = '0;
            last_scroll_d = time_now_q;
          end
        end
      end
      stv_pkg::ST_TICK: begin
        time_now_d = alu_sum;
      end
      stv_pkg::ST_ELAPSED: begin
        diff_d = alu_sum;
      end
      stv_pkg::ST_STEP: begin
        last_scroll_d = time_now_q;
        scroll_pos_d  = (pos_inc > last_pos) ? '0 : pos_inc;
      end
      stv_pkg::ST_ARM: begin
        pause_until_d = alu_sum;
      end
      default: begin
        time_now_d = time_now_q;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= stv_pkg::ST_IDLE;
      time_now_q    <= '0;
      last_scroll_q <= '0;
      pause_until_q <= '0;
      text_len_q    <= '0;
      load_cnt_q    <= '0;
      scroll_pos_q  <= '0;
      loading_q     <= 1'b0;
      zero_seen_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      time_now_q    <= time_now_d;
      last_scroll_q <= last_scroll_d;
      pause_until_q <= pause_until_d;
      text_len_q    <= text_len_d;
      load_cnt_q    <= load_cnt_d;
      scroll_pos_q  <= scroll_pos_d;
      loading_q     <= loading_d;
      zero_seen_q   <= zero_seen_d;
    end
  end

  // elapsed time scratch
  always_ff @(posedge clk_i) begin
    diff_q <= diff_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scroll_ivl_q <= stv_pkg::SCROLL_IVL_RST;
      end_pause_q  <= stv_pkg::END_PAUSE_RST;
    end else if (cfg_we_i) begin
      case (stv_pkg::cfg_reg_e'(cfg_idx_i))
        stv_pkg::REG_SCROLL_INTERVAL: scroll_ivl_q <= cfg_data_i;
        stv_pkg::REG_END_PAUSE:       end_pause_q  <= cfg_data_i;
        default:                      scroll_ivl_q <= scroll_ivl_q;
      endcase
    end
  end

  // shared adder
  stv_alu u_alu (
    .op_i    (alu_op),
    .sum_o   (alu_sum),
    .carry_o (alu_co)
  );

  // text store
  stv_ram #(
    .WIDTH (stv_pkg::CHAR_W),
    .DEPTH (stv_pkg::TEXT_DEPTH)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (wr_ok),
    .waddr_i (eff_cnt),
    .wdata_i (s_axis_tdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // frame generator
  stv_frame u_frame (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (frm_req),
    .sts_o     (frm_sts),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .pos_o     (frm_pos),
    .char_o    (frm_char),
    .last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {{(stv_pkg::OUT_DATA_W - stv_pkg::COL_W - stv_pkg::CHAR_W){1'b0}},
                         frm_char, frm_pos};

`ifndef SYNTHESIS
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_gt_win |-> (scroll_pos_q <= last_pos))
    else $error("scroll position past the end position");

  a_short_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !len_gt_win |-> (scroll_pos_q == '0))
    else $error("short text has moved");

  a_idle_no_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !frm_sts.busy)
    else $error("input taken while a frame is being built");
`endif

endmodule
